@@ sv/rcpwm_pkg.sv @@
// ----------------------------------------------------------------------------
// rcpwm_pkg
// Shared constants and types for the rc pwm throttle decoder.
// ----------------------------------------------------------------------------
package rcpwm_pkg;

  localparam int unsigned W_WIDTH  = 16;
  localparam int unsigned LW_WIDTH = 12;
  localparam int unsigned MIN_W    = 11;
  localparam int unsigned MAX_W    = 12;
  localparam int unsigned DUTY_W   = 16;
  localparam int unsigned ACT_W    = 2;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned DIV_STEPS = DUTY_W;
  localparam int unsigned CNT_W    = $clog2(DIV_STEPS);

  localparam logic [W_WIDTH-1:0] PULSE_MIN_US = 16'd500;
  localparam logic [W_WIDTH-1:0] PULSE_MAX_US = 16'd3000;
  localparam logic [DUTY_W-1:0]  DUTY_SAT     = 16'hFFFF;

  localparam logic [ACT_W-1:0] ACT_STOP    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SET     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TIMEOUT = 2'd2;

  localparam logic       OP_PULSE   = 1'b0;
  localparam logic       OP_TIMEOUT = 1'b1;

  localparam logic [2:0] REG_ENABLE    = 3'd0;
  localparam logic [2:0] REG_MIN_WIDTH = 3'd1;
  localparam logic [2:0] REG_MAX_WIDTH = 3'd2;
  localparam logic [2:0] REG_STOP_THR  = 3'd3;
  localparam logic [2:0] REG_START_LO  = 3'd4;
  localparam logic [2:0] REG_START_HI  = 3'd5;
  localparam logic [2:0] REG_HOLD_TIME = 3'd6;

  localparam logic              RST_ENABLE    = 1'b1;
  localparam logic [MIN_W-1:0]  RST_MIN_WIDTH = 11'd1000;
  localparam logic [MAX_W-1:0]  RST_MAX_WIDTH = 12'd2000;
  localparam logic [DUTY_W-1:0] RST_STOP_THR  = 16'd1966;
  localparam logic [DUTY_W-1:0] RST_START_LO  = 16'd3932;
  localparam logic [DUTY_W-1:0] RST_START_HI  = 16'd13107;
  localparam logic [DUTY_W-1:0] RST_HOLD_TIME = 16'd100;

  typedef struct packed {
    logic              enable;
    logic [MIN_W-1:0]  min_width;
    logic [MAX_W-1:0]  max_width;
    logic [DUTY_W-1:0] stop_threshold;
    logic [DUTY_W-1:0] start_low;
    logic [DUTY_W-1:0] start_high;
    logic [DUTY_W-1:0] hold_time;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic upd_width;
    logic div_init;
    logic div_step;
    logic load_out;
    logic notice;
  } cmd_t;

  typedef struct packed {
    logic enable;
    logic op;
    logic pulse_ok;
    logic had_width;
  } sts_t;

endpackage

@@ sv/rcpwm_regs.sv @@
// ----------------------------------------------------------------------------
// rcpwm_regs
// APB-style configuration registers with read back.
// ----------------------------------------------------------------------------
module rcpwm_regs
  import rcpwm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_ENABLE:    cfg_nxt.enable         = pwdata[0];
        REG_MIN_WIDTH: cfg_nxt.min_width      = pwdata[MIN_W-1:0];
        REG_MAX_WIDTH: cfg_nxt.max_width      = pwdata[MAX_W-1:0];
        REG_STOP_THR:  cfg_nxt.stop_threshold = pwdata[DUTY_W-1:0];
        REG_START_LO:  cfg_nxt.start_low      = pwdata[DUTY_W-1:0];
        REG_START_HI:  cfg_nxt.start_high     = pwdata[DUTY_W-1:0];
        REG_HOLD_TIME: cfg_nxt.hold_time      = pwdata[DUTY_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_ENABLE:    prdata = {{(DATA_W-1){1'b0}}, cfg_r.enable};
      REG_MIN_WIDTH: prdata = {{(DATA_W-MIN_W){1'b0}}, cfg_r.min_width};
      REG_MAX_WIDTH: prdata = {{(DATA_W-MAX_W){1'b0}}, cfg_r.max_width};
      REG_STOP_THR:  prdata = {{(DATA_W-DUTY_W){1'b0}}, cfg_r.stop_threshold};
      REG_START_LO:  prdata = {{(DATA_W-DUTY_W){1'b0}}, cfg_r.start_low};
      REG_START_HI:  prdata = {{(DATA_W-DUTY_W){1'b0}}, cfg_r.start_high};
      REG_HOLD_TIME: prdata = {{(DATA_W-DUTY_W){1'b0}}, cfg_r.hold_time};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable         <= RST_ENABLE;
      cfg_r.min_width      <= RST_MIN_WIDTH;
      cfg_r.max_width      <= RST_MAX_WIDTH;
      cfg_r.stop_threshold <= RST_STOP_THR;
      cfg_r.start_low      <= RST_START_LO;
      cfg_r.start_high     <= RST_START_HI;
      cfg_r.hold_time      <= RST_HOLD_TIME;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ sv/rcpwm_dp.sv @@
// ----------------------------------------------------------------------------
// rcpwm_dp
// Datapath: input capture, stored width, clamp, bit-serial divider,
// start/stop decision and output register.
// ----------------------------------------------------------------------------
module rcpwm_dp
  import rcpwm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               in_op,
  input  logic [W_WIDTH-1:0] in_width_us,
  input  logic               in_motor_idle,
  output logic [ACT_W-1:0]   out_action,
  output logic [DUTY_W-1:0]  out_duty,
  output logic [DUTY_W-1:0]  out_hold_ms
);

  logic                op_r;
  logic                idle_r;
  logic [W_WIDTH-1:0]  w_r;
  logic [LW_WIDTH-1:0] last_width_r;
  logic [LW_WIDTH-1:0] last_width_nxt;
  logic [LW_WIDTH-1:0] rem_r;
  logic [LW_WIDTH-1:0] den_r;
  logic [DUTY_W-1:0]   quo_r;
  logic                sat_r;
  logic                empty_r;
  logic [ACT_W-1:0]    act_r;
  logic [DUTY_W-1:0]   duty_r;
  logic [DUTY_W-1:0]   hold_r;

  logic [LW_WIDTH-1:0] lo;
  logic [LW_WIDTH-1:0] hi;
  logic [LW_WIDTH-1:0] wc;
  logic [LW_WIDTH-1:0] num;
  logic [LW_WIDTH-1:0] span;
  logic [LW_WIDTH:0]   rem2;
  logic [LW_WIDTH:0]   rem_sub;
  logic                take;
  logic [DUTY_W-1:0]   duty;
  logic                stop;

  assign lo = {{(LW_WIDTH-MIN_W){1'b0}}, cfg.min_width};
  assign hi = cfg.max_width;

  always_comb begin
    wc = w_r[LW_WIDTH-1:0];
    if (wc < lo) wc = lo;
    if (wc > hi) wc = hi;
  end

  assign num  = wc - lo;
  assign span = hi - lo;

  assign sts.enable    = cfg.enable;
  assign sts.op        = op_r;
  assign sts.pulse_ok  = (w_r >= PULSE_MIN_US) && (w_r <= PULSE_MAX_US);
  assign sts.had_width = (last_width_r != '0);

  // one quotient bit per cycle; the remainder stays below the divisor when it starts below it
  assign rem2    = {rem_r, 1'b0};
  assign take    = (rem2 >= {1'b0, den_r});
  assign rem_sub = rem2 - {1'b0, den_r};

  always_comb begin
    if (empty_r) begin
      duty = '0;
    end else if (sat_r) begin
      duty = DUTY_SAT;
    end else begin
      duty = quo_r;
    end
    stop = 1'b0;
    if (idle_r && ((duty < cfg.start_low) || (duty > cfg.start_high))) begin
      stop = 1'b1;
    end else if (duty < cfg.stop_threshold) begin
      stop = 1'b1;
    end
    if (duty == '0) stop = 1'b1;
  end

  always_comb begin
    last_width_nxt = last_width_r;
    if (cmd.upd_width) begin
      if (op_r == OP_TIMEOUT) begin
        last_width_nxt = '0;
      end else if (sts.pulse_ok) begin
        last_width_nxt = w_r[LW_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_width_r <= '0;
    end else begin
      last_width_r <= last_width_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= in_op;
      idle_r <= in_motor_idle;
      w_r    <= in_width_us;
    end
    if (cmd.div_init) begin
      rem_r   <= num;
      den_r   <= span;
      quo_r   <= '0;
      sat_r   <= (num == span);
      empty_r <= (hi <= lo);
    end else if (cmd.div_step) begin
      rem_r <= take ? rem_sub[LW_WIDTH-1:0] : rem2[LW_WIDTH-1:0];
      quo_r <= {quo_r[DUTY_W-2:0], take};
    end
    if (cmd.load_out) begin
      if (cmd.notice) begin
        act_r  <= ACT_TIMEOUT;
        duty_r <= '0;
        hold_r <= '0;
      end else if (stop) begin
        act_r  <= ACT_STOP;
        duty_r <= '0;
        hold_r <= '0;
      end else begin
        act_r  <= ACT_SET;
        duty_r <= duty;
        hold_r <= cfg.hold_time;
      end
    end
  end

  assign out_action  = act_r;
  assign out_duty    = duty_r;
  assign out_hold_ms = hold_r;

endmodule

@@ sv/rcpwm_ctrl.sv @@
// ----------------------------------------------------------------------------
// rcpwm_ctrl
// Controller: transaction sequencing, divider step count and output valid.
// ----------------------------------------------------------------------------
module rcpwm_ctrl
  import rcpwm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state_r;
  logic [1:0]       state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             notice_r;
  logic             notice_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    notice_nxt   = notice_r;
    cmd          = '0;
    cmd.notice   = notice_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_PREP;
        end
      end
      S_PREP: begin
        notice_nxt = 1'b0;
        state_nxt  = S_IDLE;
        if (sts.enable) begin
          cmd.upd_width = 1'b1;
          if (sts.op == OP_TIMEOUT) begin
            if (sts.had_width) begin
              notice_nxt = 1'b1;
              state_nxt  = S_DONE;
            end
          end else if (sts.pulse_ok) begin
            cmd.div_init = 1'b1;
            cnt_nxt      = '0;
            state_nxt    = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      notice_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      notice_r    <= notice_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ sv/rc_pwm_throttle_decoder.sv @@
// ----------------------------------------------------------------------------
// rc_pwm_throttle_decoder
// Turns measured rc pulse widths and timeout events into motor commands.
//
// The input channel (in_valid/in_ready) carries one event per transaction:
// a pulse width in microseconds (in_op low) or a timeout (in_op high),
// together with the motor idle flag. The output channel (out_valid/
// out_ready) carries at most one command per event: stop, set duty with
// the hold time, or a timeout notice. Events that give no command are
// absorbed silently.
// A valid pulse, once accepted, goes through the clamp and divider set-up,
// the one-bit-per-cycle divider and the load into the output register,
// which raises out_valid. Timeouts and dropped events skip the divider;
// only a timeout notice goes on to the output load. One event is in
// flight at a time: a new event is accepted only after the last is done.
// The result sits in an output register; while the receiver stalls, the
// next event is still accepted and worked on, and waits before the output
// register until it frees up.
// Reset clears the stored width, empties both channels and loads the
// configuration registers with their defaults.
// ----------------------------------------------------------------------------
module rc_pwm_throttle_decoder
  import rcpwm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [W_WIDTH-1:0] in_width_us,
  input  logic               in_motor_idle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ACT_W-1:0]   out_action,
  output logic [DUTY_W-1:0]  out_duty,
  output logic [DUTY_W-1:0]  out_hold_ms,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [ADDR_W-1:0]  cfg_paddr,
  input  logic [DATA_W-1:0]  cfg_pwdata,
  output logic [DATA_W-1:0]  cfg_prdata,
  output logic               cfg_pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  rcpwm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  rcpwm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rcpwm_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (cmd),
    .sts           (sts),
    .in_op         (in_op),
    .in_width_us   (in_width_us),
    .in_motor_idle (in_motor_idle),
    .out_action    (out_action),
    .out_duty      (out_duty),
    .out_hold_ms   (out_hold_ms)
  );

endmodule
